// ===== src/fractal_value_noise_2d_macros.svh =====
// Assertion macros for the fractal value noise block.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef FRACTAL_VALUE_NOISE_2D_MACROS_SVH
`define FRACTAL_VALUE_NOISE_2D_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define FVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define FVN_ASSERT_IMP(lbl, pre, post, msg) `FVN_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication.
`define FVN_ASSERT_NXT(lbl, pre, post, msg) `FVN_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== src/fvn_pkg.sv =====
// Shared types, constants and functions of the fractal value noise block.
// No dependencies.
`default_nettype none

package fvn_pkg;

  // Pipeline stage numbering.
  localparam int unsigned ST_IN       = 0;
  localparam int unsigned ST_HASH_N   = 1;
  localparam int unsigned ST_HASH_SQ  = 2;
  localparam int unsigned ST_HASH_POL = 3;
  localparam int unsigned ST_HASH_MUL = 4;
  localparam int unsigned ST_HASH_DIV = 5;
  localparam int unsigned ST_LERP_Y   = 6;
  localparam int unsigned ST_LERP_X   = 7;
  localparam int unsigned ST_SUM      = 8;
  localparam int unsigned N_STAGES    = 9;

  typedef logic [N_STAGES-1:0] stage_en_t;

  localparam int unsigned LEVEL_LO    = 1;
  localparam int unsigned LEVEL_HI    = 7;
  localparam int unsigned MAX_OCTAVES = 8;

  localparam int unsigned CFG_W    = 4;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned HASH_T_W = 31;

  typedef enum logic [0:0] {
    REG_OCTAVES      = 1'b0,
    REG_PERIOD_LOG2  = 1'b1
  } cfg_reg_e;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [15:0] HASH_DIV   = 16'd32767;

  // Wrap mask of one level: ((1 << period) >> level) - 1, all ones when that is zero.
  function automatic logic [15:0] level_mask(input logic [CFG_W-1:0] period,
                                             input logic [2:0] level);
    logic [16:0] one_hot;
    one_hot = 17'd0;
    if (period >= {1'b0, level}) begin
      one_hot = 17'd1 << (period - {1'b0, level});
      return 16'(one_hot - 17'd1);
    end
    return 16'hFFFF;
  endfunction

  // Quotient by 2^15 - 1, truncated to 16 bits, using t = a * 32767 + (a + b).
  function automatic logic [15:0] div_7fff(input logic [HASH_T_W-1:0] t);
    logic [15:0] a;
    logic [14:0] b;
    logic [16:0] s;
    logic [15:0] cd;
    logic [16:0] q;
    a  = t[30:15];
    b  = t[14:0];
    s  = 17'(a) + 17'(b);
    cd = 16'(s[16:15]) + 16'(s[14:0]);
    q  = 17'(a) + 17'(s[16:15]) + 17'(cd >= HASH_DIV);
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/fvn_hash.sv =====
// Five-stage pipelined integer hash of one lattice corner.
// Depends on fvn_pkg.
`default_nettype none

module fvn_hash #(
  parameter int unsigned COORD_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire fvn_pkg::stage_en_t    go_i,
  input  wire logic [COORD_BITS-1:0] corner_x_i,
  input  wire logic [COORD_BITS-1:0] corner_y_i,
  output logic [15:0]                hash_o
);

  logic [31:0] n_lin;
  logic [31:0] n1_d, n1_q;
  logic [31:0] nn2_d, nn2_q, n2_q;
  logic [31:0] a3_d, a3_q, n3_q;
  logic [fvn_pkg::HASH_T_W-1:0] t4_d, t4_q;
  logic [15:0] h5_d, h5_q;

  always_comb begin
    n_lin = 32'(corner_x_i) + 32'(corner_y_i) * fvn_pkg::HASH_MUL_Y;
    n1_d  = (n_lin << fvn_pkg::HASH_SHIFT) ^ n_lin;
    nn2_d = n1_q * n1_q;
    a3_d  = nn2_q * fvn_pkg::HASH_C1 + fvn_pkg::HASH_C2;
    t4_d  = fvn_pkg::HASH_T_W'(n3_q * a3_q + fvn_pkg::HASH_C3);
    h5_d  = fvn_pkg::div_7fff(t4_q);
  end

  always_ff @(posedge clk_i) begin
    if (go_i[fvn_pkg::ST_HASH_N]) begin
      n1_q <= n1_d;
    end
    if (go_i[fvn_pkg::ST_HASH_SQ]) begin
      nn2_q <= nn2_d;
      n2_q  <= n1_q;
    end
    if (go_i[fvn_pkg::ST_HASH_POL]) begin
      a3_q <= a3_d;
      n3_q <= n2_q;
    end
    if (go_i[fvn_pkg::ST_HASH_MUL]) begin
      t4_q <= t4_d;
    end
    if (go_i[fvn_pkg::ST_HASH_DIV]) begin
      h5_q <= h5_d;
    end
  end

  assign hash_o = h5_q;

endmodule

`default_nettype wire

// ===== src/fvn_level.sv =====
// One octave level: corner wrap, four corner hashes and bilinear blend.
// Depends on fvn_pkg and fvn_hash.
`default_nettype none

module fvn_level #(
  parameter int unsigned COORD_BITS = 15,
  parameter int unsigned LEVEL      = 1
) (
  input  wire logic                       clk_i,
  input  wire fvn_pkg::stage_en_t         go_i,
  input  wire logic [COORD_BITS-1:0]      coord_x_i,
  input  wire logic [COORD_BITS-1:0]      coord_y_i,
  input  wire logic [fvn_pkg::CFG_W-1:0]  period_i,
  input  wire logic                       level_on_i,
  output logic [fvn_pkg::NOISE_W-1:0]     contrib_o
);

  localparam int unsigned STEP_W = LEVEL + 1;
  localparam int unsigned LR_W   = 16 + LEVEL;
  localparam int unsigned BL_W   = 16 + 2 * LEVEL;
  localparam logic [STEP_W-1:0] STEP = STEP_W'(1) << LEVEL;

  logic [15:0]           mask_full;
  logic [COORD_BITS-1:0] mask;
  logic [COORD_BITS-1:0] cx0, cx1, cy0, cy1;
  logic [15:0]           h00, h10, h11, h01;

  logic [LEVEL-1:0] fx_q [fvn_pkg::ST_HASH_N:fvn_pkg::ST_HASH_DIV];
  logic [LEVEL-1:0] fy_q [fvn_pkg::ST_HASH_N:fvn_pkg::ST_HASH_DIV];
  logic [LEVEL-1:0] fx6_q;

  logic [STEP_W-1:0] wfy, wfx;
  logic [LR_W-1:0]   left_d, right_d, left_q, right_q;
  logic [BL_W-1:0]   blend;
  logic [fvn_pkg::NOISE_W-1:0] contrib_d, contrib_q;

  always_comb begin
    mask_full = fvn_pkg::level_mask(period_i, 3'(LEVEL));
    mask      = mask_full[COORD_BITS-1:0];
    cx0 = COORD_BITS'(coord_x_i >> LEVEL);
    cy0 = COORD_BITS'(coord_y_i >> LEVEL);
    cx1 = (cx0 + COORD_BITS'(1)) & mask;
    cy1 = (cy0 + COORD_BITS'(1)) & mask;
    cx0 = cx0 & mask;
    cy0 = cy0 & mask;
  end

  fvn_hash #(.COORD_BITS(COORD_BITS)) u_hash_00 (
    .clk_i(clk_i), .go_i(go_i), .corner_x_i(cx0), .corner_y_i(cy0), .hash_o(h00)
  );
  fvn_hash #(.COORD_BITS(COORD_BITS)) u_hash_10 (
    .clk_i(clk_i), .go_i(go_i), .corner_x_i(cx1), .corner_y_i(cy0), .hash_o(h10)
  );
  fvn_hash #(.COORD_BITS(COORD_BITS)) u_hash_11 (
    .clk_i(clk_i), .go_i(go_i), .corner_x_i(cx1), .corner_y_i(cy1), .hash_o(h11)
  );
  fvn_hash #(.COORD_BITS(COORD_BITS)) u_hash_01 (
    .clk_i(clk_i), .go_i(go_i), .corner_x_i(cx0), .corner_y_i(cy1), .hash_o(h01)
  );

  always_ff @(posedge clk_i) begin
    if (go_i[fvn_pkg::ST_HASH_N]) begin
      fx_q[fvn_pkg::ST_HASH_N] <= coord_x_i[LEVEL-1:0];
      fy_q[fvn_pkg::ST_HASH_N] <= coord_y_i[LEVEL-1:0];
    end
    for (int unsigned s = fvn_pkg::ST_HASH_N + 1; s <= fvn_pkg::ST_HASH_DIV; s++) begin
      if (go_i[s]) begin
        fx_q[s] <= fx_q[s-1];
        fy_q[s] <= fy_q[s-1];
      end
    end
  end

  always_comb begin
    wfy     = STEP - STEP_W'(fy_q[fvn_pkg::ST_HASH_DIV]);
    left_d  = LR_W'(fy_q[fvn_pkg::ST_HASH_DIV]) * LR_W'(h01) + LR_W'(wfy) * LR_W'(h00);
    right_d = LR_W'(fy_q[fvn_pkg::ST_HASH_DIV]) * LR_W'(h11) + LR_W'(wfy) * LR_W'(h10);
    wfx     = STEP - STEP_W'(fx6_q);
    blend   = BL_W'(right_q) * BL_W'(fx6_q) + BL_W'(left_q) * BL_W'(wfx);
    contrib_d = level_on_i ? fvn_pkg::NOISE_W'(blend[BL_W-1:LEVEL+8]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (go_i[fvn_pkg::ST_LERP_Y]) begin
      left_q  <= left_d;
      right_q <= right_d;
      fx6_q   <= fx_q[fvn_pkg::ST_HASH_DIV];
    end
    if (go_i[fvn_pkg::ST_LERP_X]) begin
      contrib_q <= contrib_d;
    end
  end

  assign contrib_o = contrib_q;

endmodule

`default_nettype wire

// ===== src/fractal_value_noise_2d.sv =====
// Top level of the tileable 2-D fractal value noise generator.
// Depends on fvn_pkg, fvn_level, fvn_hash and fractal_value_noise_2d_macros.svh.
//
//   Channel   Direction  Transfer                  Contents
//   s_axis    in         tvalid & tready           coord_x, coord_y
//   m_axis    out        tvalid & tready           noise_value
//   cfg       in         cfg_we_i                  octaves, period_log2
//
// One transaction per cycle is sustained while m_axis_tready is high; an item passes nine
// register stages of the hash and blend path, from x0_q to sum_q, before m_axis_tvalid rises.
// Every stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so bubbles are filled and a stall on m_axis loses nothing.
// Reset clears the valid bits and loads 8 octaves and period_log2 8.
`default_nettype none

module fractal_value_noise_2d #(
  parameter int unsigned COORD_BITS = 15
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [COORD_BITS-1:0] coord_x, [2*COORD_BITS-1:COORD_BITS] coord_y, zero padding above.
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [15:0] noise_value.
  output logic [fvn_pkg::NOISE_W-1:0]     m_axis_tdata,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_addr_i,
  input  wire logic [fvn_pkg::CFG_W-1:0]  cfg_data_i
);

  `include "fractal_value_noise_2d_macros.svh"

  localparam int unsigned N  = fvn_pkg::N_STAGES;
  localparam int unsigned LX = fvn_pkg::ST_LERP_X;

  logic [fvn_pkg::CFG_W-1:0] octave_q, period_q;
  logic [N-1:0]              v_q;
  fvn_pkg::stage_en_t        go;
  logic [COORD_BITS-1:0]     x0_q, y0_q;
  logic [fvn_pkg::NOISE_W-1:0] contrib [fvn_pkg::LEVEL_LO:fvn_pkg::LEVEL_HI];
  logic [fvn_pkg::NOISE_W-1:0] sum_d, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= fvn_pkg::CFG_W'(fvn_pkg::MAX_OCTAVES);
      period_q <= fvn_pkg::CFG_W'(8);
    end else if (cfg_we_i) begin
      case (fvn_pkg::cfg_reg_e'(cfg_addr_i))
        fvn_pkg::REG_OCTAVES:      octave_q <= cfg_data_i;
        fvn_pkg::REG_PERIOD_LOG2:  period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    go[N-1] = !v_q[N-1] || m_axis_tready;
    for (int i = N - 2; i >= 0; i--) begin
      go[i] = !v_q[i] || go[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int unsigned i = 1; i < N; i++) begin
        if (go[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[fvn_pkg::ST_IN]) begin
      x0_q <= s_axis_tdata[COORD_BITS-1:0];
      y0_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  for (genvar k = fvn_pkg::LEVEL_LO; k <= fvn_pkg::LEVEL_HI; k++) begin : g_level
    logic level_on;
    assign level_on = octave_q >= fvn_pkg::CFG_W'(fvn_pkg::MAX_OCTAVES + 1 - k);

    fvn_level #(
      .COORD_BITS(COORD_BITS),
      .LEVEL     (k)
    ) u_level (
      .clk_i     (clk_i),
      .go_i      (go),
      .coord_x_i (x0_q),
      .coord_y_i (y0_q),
      .period_i  (period_q),
      .level_on_i(level_on),
      .contrib_o (contrib[k])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int unsigned k = fvn_pkg::LEVEL_LO; k <= fvn_pkg::LEVEL_HI; k++) begin
      sum_d = sum_d + contrib[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[fvn_pkg::ST_SUM]) begin
      sum_q <= sum_d;
    end
  end

  assign s_axis_tready = go[fvn_pkg::ST_IN];
  assign m_axis_tvalid = v_q[fvn_pkg::ST_SUM];
  assign m_axis_tdata  = sum_q;

  `FVN_ASSERT_IMP(a_rdy_empty, !v_q[fvn_pkg::ST_IN], s_axis_tready, "empty entry not ready")
  `FVN_ASSERT_IMP(a_full_stall, (&v_q) && !m_axis_tready, !s_axis_tready, "full but ready")
  `FVN_ASSERT_NXT(a_blend_hold, v_q[LX] && !go[LX], v_q[LX], "stalled blend item lost")
  `FVN_ASSERT_IMP(a_out_origin, $rose(m_axis_tvalid), $past(v_q[LX]), "valid without source")

endmodule

`default_nettype wire

// ===== sim/fractal_value_noise_2d_tb.sv =====
// Self-checking testbench for fractal_value_noise_2d: streams pixel coordinates under
// several register settings and compares every noise sample against a local predictor.
// Depends on fvn_pkg and the fractal_value_noise_2d RTL only.
`timescale 1ns / 100ps

module fractal_value_noise_2d_tb;

  localparam int unsigned COORD_BITS   = 15;
  localparam int unsigned DATA_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned STALL_LIMIT  = 1000;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } coord_t;

  typedef struct {
    logic [15:0]           noise;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } noise_exp_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [DATA_W-1:0]             s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fvn_pkg::NOISE_W-1:0]   m_axis_tdata;
  logic                          cfg_we_i = 1'b0;
  logic [0:0]                    cfg_addr_i = '0;
  logic [fvn_pkg::CFG_W-1:0]     cfg_data_i = '0;

  coord_t     coord_queue[$];
  noise_exp_t noise_expected[$];

  logic [3:0]  cfg_octaves = 4'd8;
  logic [3:0]  cfg_period = 4'd8;
  bit          idling_on = 1'b1;
  logic        in_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned stall_cycles = 0;
  int unsigned fault_count = 0;
  int unsigned coords_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned setting_count = 0;

  fractal_value_noise_2d #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] mask);
    logic [31:0] n;
    logic [31:0] t;
    n = (cx & mask) + (cy & mask) * 32'd57;
    n = (n << 13) ^ n;
    t = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
    t = t & 32'h7fff_ffff;
    t = t / 32'h7fff;
    return t[15:0];
  endfunction

  function automatic logic [15:0] octave_blend(input logic [COORD_BITS-1:0] px,
                                               input logic [COORD_BITS-1:0] py,
                                               input int unsigned lvl, input logic [3:0] period);
    logic [31:0] step, mask, cx, cy, fx, fy;
    logic [31:0] h00, h10, h11, h01, left, right, blend;
    step  = 32'd1 << lvl;
    mask  = ((32'd1 << period) >> lvl) - 32'd1;
    cx    = 32'(px) >> lvl;
    cy    = 32'(py) >> lvl;
    h00   = 32'(lattice_hash(cx, cy, mask));
    h10   = 32'(lattice_hash(cx + 32'd1, cy, mask));
    h11   = 32'(lattice_hash(cx + 32'd1, cy + 32'd1, mask));
    h01   = 32'(lattice_hash(cx, cy + 32'd1, mask));
    fx    = 32'(px) & (step - 32'd1);
    fy    = 32'(py) & (step - 32'd1);
    left  = fy * h01 + (step - fy) * h00;
    right = fy * h11 + (step - fy) * h10;
    blend = (right * fx + left * (step - fx)) >> (2 * lvl);
    return blend[15:0];
  endfunction

  function automatic logic [15:0] predict_noise(input logic [COORD_BITS-1:0] px,
                                                input logic [COORD_BITS-1:0] py,
                                                input logic [3:0] octaves,
                                                input logic [3:0] period);
    int unsigned eff;
    logic [15:0] sum;
    eff = (octaves > 4'd8) ? 8 : int'(octaves);
    sum = 16'd0;
    if (eff >= 2) begin
      for (int unsigned lvl = 9 - eff; lvl < 8; lvl++) begin
        sum = sum + (octave_blend(px, py, lvl, period) >> (8 - lvl));
      end
    end
    return sum;
  endfunction

  // Source side: a transaction stays valid until it is taken; gaps fall between items.
  always @(negedge clk_i) begin : coord_driver
    coord_t item;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (coord_queue.size() != 0) begin
        item = coord_queue.pop_front();
        s_axis_tdata <= DATA_W'({item.y, item.x});
        s_axis_tvalid <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink_driver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      sink_gap <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : noise_checker
    noise_exp_t exp_item;
    logic       moved;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      moved = cfg_we_i;
      if (cfg_we_i) begin
        if (cfg_addr_i == fvn_pkg::REG_OCTAVES) cfg_octaves = cfg_data_i;
        else cfg_period = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_item.x = s_axis_tdata[COORD_BITS-1:0];
        exp_item.y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        exp_item.noise = predict_noise(exp_item.x, exp_item.y, cfg_octaves, cfg_period);
        noise_expected.push_back(exp_item);
        coords_sent++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (noise_expected.size() == 0) begin
          $error("noise_value: unexpected sample %0h with nothing pending", m_axis_tdata);
          fault_count++;
        end else begin
          exp_item = noise_expected.pop_front();
          samples_checked++;
          if (m_axis_tdata !== exp_item.noise) begin
            $error("noise_value mismatch at (%0d,%0d): expected %0h, actual %0h",
                   exp_item.x, exp_item.y, exp_item.noise, m_axis_tdata);
            fault_count++;
          end
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (coord_queue.size() != 0 || s_axis_tvalid || noise_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [3:0] octaves, input logic [3:0] period);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= fvn_pkg::REG_OCTAVES;
    cfg_data_i <= octaves;
    @(negedge clk_i);
    cfg_addr_i <= fvn_pkg::REG_PERIOD_LOG2;
    cfg_data_i <= period;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    setting_count++;
  endtask

  task automatic queue_coord(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    coord_t item;
    item.x = x;
    item.y = y;
    coord_queue.push_back(item);
  endtask

  // Mixes full-range coordinates with ones at the tiling edge and near the origin.
  task automatic queue_random(input int unsigned count, input logic [3:0] period);
    logic [31:0] edge_pos;
    logic [COORD_BITS-1:0] x, y;
    for (int unsigned i = 0; i < count; i++) begin
      edge_pos = (32'd1 << period) - 32'd1 - 32'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0, 1: begin
          x = COORD_BITS'($urandom_range(0, 32767));
          y = COORD_BITS'($urandom_range(0, 32767));
        end
        2: begin
          x = edge_pos[COORD_BITS-1:0];
          y = ($urandom_range(0, 1) == 0) ? edge_pos[COORD_BITS-1:0]
                                          : COORD_BITS'($urandom_range(0, 32767));
        end
        default: begin
          x = COORD_BITS'($urandom_range(0, 511));
          y = COORD_BITS'($urandom_range(0, 511));
        end
      endcase
      queue_coord(x, y);
    end
  endtask

  initial begin : stimulus
    logic [3:0] oct, per;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    setting_count = 1;

    queue_coord(15'd0, 15'd0);
    queue_coord(15'h7fff, 15'h7fff);
    queue_coord(15'h7fff, 15'd0);
    queue_coord(15'd0, 15'h7fff);
    queue_coord(15'h5555, 15'h2aaa);
    queue_coord(15'h2aaa, 15'h5555);
    queue_coord(15'd255, 15'd255);
    queue_coord(15'd256, 15'd256);
    queue_coord(15'd127, 15'd128);
    queue_coord(15'd1, 15'd1);
    queue_coord(15'd128, 15'd127);
    queue_coord(15'd12345, 15'd23456);

    // With zero or one octave the sum must stay zero.
    load_settings(4'd0, 4'd8);
    queue_coord(15'h7fff, 15'h7fff);
    queue_coord(15'd100, 15'd200);
    queue_coord(15'd0, 15'd0);
    load_settings(4'd1, 4'd15);
    queue_coord(15'h7fff, 15'h7fff);
    queue_coord(15'd5000, 15'd6000);

    // Octave count saturates, and a tiny period leaves corner indices unwrapped.
    load_settings(4'd15, 4'd0);
    queue_coord(15'h7fff, 15'd1);
    queue_coord(15'd129, 15'd255);
    queue_coord(15'd0, 15'd0);
    queue_coord(15'h7fff, 15'h7fff);

    load_settings(4'd8, 4'd8);
    queue_random(50, 4'd8);
    load_settings(4'd2, 4'd7);
    queue_random(50, 4'd7);
    load_settings(4'd8, 4'd15);
    queue_random(50, 4'd15);

    load_settings(4'd5, 4'd11);
    idling_on = 1'b0;
    queue_random(40, 4'd11);
    wait_drained();
    idling_on = 1'b1;

    for (int i = 0; i < 4; i++) begin
      if (i == 3) begin
        oct = 4'($urandom_range(0, 15));
        per = 4'($urandom_range(0, 15));
      end else begin
        oct = 4'($urandom_range(2, 8));
        per = 4'($urandom_range(7, 15));
      end
      load_settings(oct, per);
      queue_random(45, per);
    end

    oct = 4'($urandom_range(2, 8));
    per = 4'($urandom_range(7, 15));
    load_settings(oct, per);
    idling_on = 1'b0;
    queue_random(60, per);

    wait_drained();
    $display("Run covered %0d coordinate transactions under %0d register settings.",
             coords_sent, setting_count);
    $display("%0d noise samples were compared, %0d faults found.", samples_checked, fault_count);
    if (fault_count == 0 && noise_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
